/* hw/rtl/kest_pkg.sv */
// shared types, codes and key-string tables for the key escape translator
package kest_pkg;

   // configuration register indexes (byte address / 4)
   localparam logic [1:0] REG_SOURCE_FORMAT      = 2'd0;
   localparam logic [1:0] REG_DELETE_TO_SEQUENCE = 2'd1;
   localparam logic [1:0] REG_APPLICATION_CURSOR = 2'd2;

   // source format codes
   localparam logic [1:0] FMT_PASS     = 2'd0;
   localparam logic [1:0] FMT_LETTER   = 2'd1;
   localparam logic [1:0] FMT_TILDE    = 2'd2;
   localparam logic [1:0] FMT_PASS_ALT = 2'd3;

   // reset values of the registers
   localparam logic [1:0] SOURCE_FORMAT_RESET      = FMT_LETTER;
   localparam logic       DELETE_TO_SEQUENCE_RESET = 1'b1;
   localparam logic       APPLICATION_CURSOR_RESET = 1'b0;

   localparam int QUEUE_DEPTH = 2;
   localparam int RUN_MAX     = 8;
   localparam int STR_MAX     = 5;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_BRACKET,
      PH_FIRST,
      PH_SECOND
   } phase_type;

   typedef struct packed {
      logic [1:0] source_format;
      logic       delete_to_sequence;
      logic       application_cursor;
   } cfg_type;

   // up to five characters, ch[0] sent first
   typedef struct packed {
      logic [STR_MAX-1:0][7:0] ch;
      logic [2:0]              len;
   } str_type;

   // one queued run of result bytes, bytes[0] sent first
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [3:0]              count;
      logic                    eoc;
   } run_type;

   function automatic str_type mk_str(input logic [2:0] len, input logic [7:0] c0,
                                      input logic [7:0] c1, input logic [7:0] c2,
                                      input logic [7:0] c3, input logic [7:0] c4);
      str_type s;
      s.len   = len;
      s.ch[0] = c0;
      s.ch[1] = c1;
      s.ch[2] = c2;
      s.ch[3] = c3;
      s.ch[4] = c4;
      return s;
   endfunction

   // ESC [ d ~
   function automatic str_type tilde1(input logic [7:0] d);
      return mk_str(3'd4, CH_ESC, CH_LBR, d, CH_TILDE, CH_NUL);
   endfunction

   // ESC [ d d ~
   function automatic str_type tilde2(input logic [7:0] d1, input logic [7:0] d2);
      return mk_str(3'd5, CH_ESC, CH_LBR, d1, d2, CH_TILDE);
   endfunction

   // ESC [ [ l
   function automatic str_type dbl_bracket(input logic [7:0] l);
      return mk_str(3'd4, CH_ESC, CH_LBR, CH_LBR, l, CH_NUL);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_arrow(input logic [7:0] b);
      return (b >= "A") && (b <= "D");
   endfunction

   // ESC [ x, or ESC O x for an arrow under application cursor
   function automatic str_type arrow_or_plain(input logic [7:0] x, input logic app);
      return mk_str(3'd3, CH_ESC, (app && is_arrow(x)) ? CH_O : CH_LBR, x, CH_NUL, CH_NUL);
   endfunction

   // letter-coded console keys, len zero when the letter is not a key
   function automatic str_type letter_key(input logic [7:0] x);
      str_type s;
      s = mk_str(3'd0, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
      unique case (x)
         "E": s = mk_str(3'd3, CH_ESC, CH_LBR, "G", CH_NUL, CH_NUL);
         "H": s = tilde1("1");
         "L": s = tilde1("2");
         "F": s = tilde1("4");
         "I": s = tilde1("5");
         "G": s = tilde1("6");
         "M": s = dbl_bracket("A");
         "N": s = dbl_bracket("B");
         "O": s = dbl_bracket("C");
         "P": s = dbl_bracket("D");
         "Q": s = dbl_bracket("E");
         "R": s = tilde2("1", "7");
         "S": s = tilde2("1", "8");
         "T": s = tilde2("1", "9");
         "U": s = tilde2("2", "0");
         "V": s = tilde2("2", "1");
         "W": s = tilde2("2", "3");
         "X": s = tilde2("2", "4");
         "Y": s = tilde2("2", "5");
         "Z": s = tilde2("2", "6");
         "a": s = tilde2("2", "8");
         "b": s = tilde2("2", "9");
         "c": s = tilde2("3", "1");
         "d": s = tilde2("3", "2");
         "e": s = tilde2("3", "3");
         "f": s = tilde2("3", "4");
         default: s = mk_str(3'd0, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
      endcase
      return s;
   endfunction

   function automatic run_type run_put(input run_type r, input logic [7:0] b);
      run_type o;
      o = r;
      if (r.count < 4'(RUN_MAX)) begin
         o.bytes[r.count[2:0]] = b;
         o.count               = r.count + 4'd1;
      end
      return o;
   endfunction

   function automatic run_type run_append(input run_type r, input str_type s);
      run_type o;
      o = r;
      for (int i = 0; i < STR_MAX; i++) begin
         if (3'(i) < s.len) begin
            o = run_put(o, s.ch[i]);
         end
      end
      return o;
   endfunction

endpackage

/* hw/rtl/kest_front.sv */
// front end: accepts raw bytes, tracks the partial sequence and builds the result run
module kest_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // in_byte
   input  logic              req_tlast,   // end_of_chunk
   input  kest_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output kest_pkg::run_type push_run
);

   kest_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          second_ff, second_in;
   logic                accept;
   logic                fmt_alt_bracket;
   kest_pkg::run_type   run;

   assign req_tready      = !queue_full;
   assign accept          = req_tvalid && !queue_full;
   assign fmt_alt_bracket = (cfg.source_format == kest_pkg::FMT_PASS_ALT) &&
                            (phase_ff == kest_pkg::PH_BRACKET);

   // next phase and held bytes
   always_comb begin
      phase_mid = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (fmt_alt_bracket) begin
         phase_mid = kest_pkg::PH_IDLE;
      end else begin
         unique case (phase_ff)
            kest_pkg::PH_IDLE: begin
               phase_mid = (req_tdata == kest_pkg::CH_ESC) ? kest_pkg::PH_ESC
                                                           : kest_pkg::PH_IDLE;
            end
            kest_pkg::PH_ESC: begin
               if (req_tdata == kest_pkg::CH_LBR) begin
                  phase_mid = kest_pkg::PH_BRACKET;
               end else if (req_tdata == kest_pkg::CH_ESC) begin
                  phase_mid = kest_pkg::PH_ESC;
               end else begin
                  phase_mid = kest_pkg::PH_IDLE;
               end
            end
            kest_pkg::PH_BRACKET: begin
               if (cfg.source_format == kest_pkg::FMT_TILDE) begin
                  phase_mid = kest_pkg::PH_FIRST;
                  first_in  = req_tdata;
               end else begin
                  phase_mid = kest_pkg::PH_IDLE;
               end
            end
            kest_pkg::PH_FIRST: begin
               if (req_tdata == kest_pkg::CH_TILDE) begin
                  phase_mid = kest_pkg::PH_IDLE;
               end else if (kest_pkg::is_digit(first_ff) && kest_pkg::is_digit(req_tdata)) begin
                  phase_mid = kest_pkg::PH_SECOND;
                  second_in = req_tdata;
               end else begin
                  phase_mid = (req_tdata == kest_pkg::CH_ESC) ? kest_pkg::PH_ESC
                                                              : kest_pkg::PH_IDLE;
               end
            end
            kest_pkg::PH_SECOND: begin
               phase_mid = (req_tdata == kest_pkg::CH_ESC) ? kest_pkg::PH_ESC
                                                           : kest_pkg::PH_IDLE;
            end
            default: phase_mid = kest_pkg::PH_IDLE;
         endcase
      end
      phase_in = req_tlast ? kest_pkg::PH_IDLE : phase_mid;
   end

   // result run for the accepted byte
   always_comb begin
      kest_pkg::str_type del_str;
      kest_pkg::str_type key_str;
      logic              feed;
      del_str = kest_pkg::tilde1("3");
      key_str = kest_pkg::letter_key(req_tdata);
      feed    = 1'b0;
      run     = '0;
      if (fmt_alt_bracket) begin
         run = kest_pkg::run_append(run,
                  kest_pkg::arrow_or_plain(req_tdata, cfg.application_cursor));
      end else begin
         unique case (phase_ff)
            kest_pkg::PH_IDLE: feed = 1'b1;
            kest_pkg::PH_ESC: begin
               if (req_tdata == kest_pkg::CH_ESC) begin
                  run = kest_pkg::run_put(run, kest_pkg::CH_ESC);
               end else if (req_tdata != kest_pkg::CH_LBR) begin
                  run  = kest_pkg::run_put(run, kest_pkg::CH_ESC);
                  feed = 1'b1;
               end
            end
            kest_pkg::PH_BRACKET: begin
               if (cfg.source_format != kest_pkg::FMT_TILDE) begin
                  if (cfg.source_format == kest_pkg::FMT_LETTER && key_str.len != 3'd0) begin
                     run = kest_pkg::run_append(run, key_str);
                  end else begin
                     run = kest_pkg::run_append(run,
                              kest_pkg::arrow_or_plain(req_tdata, cfg.application_cursor));
                  end
               end
            end
            kest_pkg::PH_FIRST: begin
               if (req_tdata == kest_pkg::CH_TILDE) begin
                  if (first_ff == "7") begin
                     run = kest_pkg::run_append(run, kest_pkg::tilde1("1"));
                  end else if (first_ff == "8") begin
                     run = kest_pkg::run_append(run, kest_pkg::tilde1("4"));
                  end else begin
                     run = kest_pkg::run_append(run,
                              kest_pkg::arrow_or_plain(first_ff, cfg.application_cursor));
                     run = kest_pkg::run_put(run, kest_pkg::CH_TILDE);
                  end
               end else if (!(kest_pkg::is_digit(first_ff) && kest_pkg::is_digit(req_tdata))) begin
                  run  = kest_pkg::run_append(run,
                            kest_pkg::arrow_or_plain(first_ff, cfg.application_cursor));
                  feed = 1'b1;
               end
            end
            kest_pkg::PH_SECOND: begin
               if (req_tdata == kest_pkg::CH_TILDE && first_ff == "1" &&
                   second_ff >= "1" && second_ff <= "5") begin
                  // F1 to F5 in the tilde numbering
                  run = kest_pkg::run_append(run,
                           kest_pkg::dbl_bracket(8'h41 + (second_ff - 8'h31)));
               end else begin
                  run = kest_pkg::run_append(run,
                           kest_pkg::mk_str(3'd4, kest_pkg::CH_ESC, kest_pkg::CH_LBR,
                                            first_ff, second_ff, kest_pkg::CH_NUL));
                  if (req_tdata == kest_pkg::CH_TILDE) begin
                     run = kest_pkg::run_put(run, kest_pkg::CH_TILDE);
                  end else begin
                     feed = 1'b1;
                  end
               end
            end
            default: run = '0;
         endcase
      end

      // byte handled afresh from idle
      if (feed) begin
         if (req_tdata == kest_pkg::CH_DEL && cfg.delete_to_sequence) begin
            run = kest_pkg::run_append(run, del_str);
         end else if (req_tdata != kest_pkg::CH_ESC) begin
            run = kest_pkg::run_put(run, req_tdata);
         end
      end

      // chunk end: anything still held goes out unchanged
      if (req_tlast) begin
         if (phase_mid != kest_pkg::PH_IDLE) begin
            run = kest_pkg::run_put(run, kest_pkg::CH_ESC);
         end
         if (phase_mid == kest_pkg::PH_BRACKET || phase_mid == kest_pkg::PH_FIRST ||
             phase_mid == kest_pkg::PH_SECOND) begin
            run = kest_pkg::run_put(run, kest_pkg::CH_LBR);
         end
         if (phase_mid == kest_pkg::PH_FIRST || phase_mid == kest_pkg::PH_SECOND) begin
            run = kest_pkg::run_put(run, first_in);
         end
         if (phase_mid == kest_pkg::PH_SECOND) begin
            run = kest_pkg::run_put(run, second_in);
         end
      end
      run.eoc = req_tlast;
   end

   assign push     = accept && (run.count != 4'd0);
   assign push_run = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= kest_pkg::PH_IDLE;
         first_ff  <= 8'h00;
         second_ff <= 8'h00;
      end else if (accept) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == kest_pkg::PH_IDLE)
      else $error("partial sequence survived a chunk end");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == kest_pkg::PH_SECOND |-> kest_pkg::is_digit(first_ff) &&
                                          kest_pkg::is_digit(second_ff))
      else $error("two-digit phase without two held digits");

   assert property (@(posedge clock) disable iff (reset)
      push |-> push_run.count <= 4'(kest_pkg::RUN_MAX))
      else $error("run longer than the byte slots");

endmodule

/* hw/rtl/kest_queue.sv */
// short queue of result runs between the front end and the back end
module kest_queue #(
   parameter int DEPTH = kest_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kest_pkg::run_type push_run,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output kest_pkg::run_type head_run
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   kest_pkg::run_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full       = (fill_ff == FILL_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_run   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("queue fill beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == FILL_W'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the fill count");

   assert property (@(posedge clock) disable iff (reset)
      push && full |-> !pop)
      else $error("run pushed into a full queue");

endmodule

/* hw/rtl/kest_back.sv */
// back end: sends the queued runs out one byte per transaction
module kest_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  kest_pkg::run_type head_run,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // out_byte
   output logic              rsp_tlast,   // last_of_run
   output logic              rsp_tuser    // chunk_done
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       load;
   logic       at_end;

   assign load   = head_valid && (!valid_ff || rsp_tready);
   assign at_end = ({1'b0, idx_ff} == (head_run.count - 4'd1));
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_run.bytes[idx_ff];
         last_in  = at_end;
         done_in  = at_end && head_run.eoc;
         idx_in   = at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> {1'b0, idx_ff} < head_run.count)
      else $error("byte index ran past the head run");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> last_ff)
      else $error("chunk end flagged on a byte that does not end its run");

   assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == 3'd0)
      else $error("byte index left mid-run with nothing queued");

endmodule

/* hw/rtl/key_escape_sequence_translator_core.sv */
// top level of the terminal key escape sequence translator
//
// req_* is the raw keyboard byte stream: tdata carries the byte, tlast marks the
// last byte of a read chunk. each accepted byte causes zero to eight bytes on
// rsp_*: tdata is the translated byte, tlast marks the final byte caused by that
// input transaction and tuser marks the last byte of a chunk.
// the front end decodes one byte per cycle while the queue has room and queues
// its whole run of result bytes; the back end sends one byte per cycle from an
// output register while the receiver is ready. the first result byte passes
// through a queue entry and then the output register. throughput: one input
// transaction per cycle while each byte gives at most one result and the receiver
// is ready; an n-byte run leaves byte by byte via the single output register, and
// the front keeps accepting until the queue of QUEUE_DEPTH runs fills.
// a stalled receiver only holds the output register; req_tready drops once the
// queue is full. reset empties the queue, drops any held partial sequence and
// loads the register defaults (letter-coded format, delete mapping on,
// application cursor off); no clearing pass is needed. the user writes registers
// over the csr_* port only while the block is idle; the block does not enforce it
module key_escape_sequence_translator_core #(
   parameter int QUEUE_DEPTH = kest_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // raw keyboard bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_chunk
   // translated bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // last_of_run
   output logic        rsp_tuser,    // [0] chunk_done
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   kest_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;
   logic [1:0]        csr_index;

   logic              queue_full;
   logic              push;
   kest_pkg::run_type push_run;
   logic              pop;
   logic              head_valid;
   kest_pkg::run_type head_run;

   // register port: no wait states, word index from the address
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            kest_pkg::REG_SOURCE_FORMAT:      cfg_in.source_format      = csr_pwdata[1:0];
            kest_pkg::REG_DELETE_TO_SEQUENCE: cfg_in.delete_to_sequence = csr_pwdata[0];
            kest_pkg::REG_APPLICATION_CURSOR: cfg_in.application_cursor = csr_pwdata[0];
            default:                          cfg_in = cfg_ff;   // unmapped word, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format      <= kest_pkg::SOURCE_FORMAT_RESET;
         cfg_ff.delete_to_sequence <= kest_pkg::DELETE_TO_SEQUENCE_RESET;
         cfg_ff.application_cursor <= kest_pkg::APPLICATION_CURSOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero-extended
   always_comb begin
      unique case (csr_index)
         kest_pkg::REG_SOURCE_FORMAT:      csr_prdata = {30'd0, cfg_ff.source_format};
         kest_pkg::REG_DELETE_TO_SEQUENCE: csr_prdata = {31'd0, cfg_ff.delete_to_sequence};
         kest_pkg::REG_APPLICATION_CURSOR: csr_prdata = {31'd0, cfg_ff.application_cursor};
         default:                          csr_prdata = 32'd0;
      endcase
   end

   // front end: sequence parser, one byte per cycle while the queue has room
   kest_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_run   (push_run)
   );

   // runs waiting for the output side
   kest_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   // back end: byte serialiser with output register
   kest_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && push |-> push_run.eoc)
      else $error("chunk end lost on its way into the queue");

   assert property (@(posedge clock) disable iff (reset)
      cfg_ff.source_format != $past(cfg_ff.source_format) |-> $past(csr_write))
      else $error("source format changed without a register write");

   assert property (@(posedge clock) disable iff (reset)
      !head_valid |=> !(rsp_tvalid && !$past(rsp_tvalid)))
      else $error("result transaction appeared with nothing queued");

endmodule
